// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the top level of the priority drain queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and ignored while rst_n is low.
`define FDQ_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and ignored while rst_n is low.
`define FDQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/fdq_pkg.sv =====
// Package with the types and constants of the four-level priority drain queue.
`default_nettype none

package fdq_pkg;

  localparam int LEVELS          = 4;
  localparam int LVL_W           = 2;
  localparam int TAG_W           = 32;
  localparam int EXT_W           = 64;
  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_TAG_BITS    = 32;

  localparam logic ACT_ENQ   = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;

  localparam logic [1:0] ST_SERVED   = 2'd0;
  localparam logic [1:0] ST_ACCEPTED = 2'd1;
  localparam logic [1:0] ST_DROPPED  = 2'd2;

  typedef struct packed {
    logic             action;
    logic [LVL_W-1:0] priority_req;
    logic [TAG_W-1:0] item_tag;
  } fdq_in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [TAG_W-1:0] served_tag;
    logic [LVL_W-1:0] served_level;
    logic             last_of_run;
  } fdq_out_t;

  typedef enum logic {
    OP_ENQ,
    OP_DRAIN
  } fdq_op_t;

  typedef struct packed {
    fdq_op_t          op;
    logic [LVL_W-1:0] level;
    logic [TAG_W-1:0] tag;
  } fdq_cmd_t;

  typedef struct packed {
    logic     valid;
    fdq_cmd_t cmd;
  } fdq_req_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fdq_front.sv =====
// Front end: accepts input beats, classifies them and buffers them in a two-entry queue.
`default_nettype none

module fdq_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire fdq_pkg::fdq_in_t in_data,
  input  wire logic             cmd_pop,
  output fdq_pkg::fdq_req_t     req
);

  fdq_pkg::fdq_cmd_t fifo_r [2];
  logic              wr_ptr_r, wr_ptr_nxt;
  logic              rd_ptr_r, rd_ptr_nxt;
  logic [1:0]        count_r, count_nxt;
  logic              push, pop;
  fdq_pkg::fdq_cmd_t new_cmd;

  assign busy = (count_r == 2'd2);
  assign push = start && !busy;
  assign pop  = cmd_pop && (count_r != 2'd0);

  always_comb begin
    new_cmd.op    = (in_data.action == fdq_pkg::ACT_DRAIN) ? fdq_pkg::OP_DRAIN
                                                           : fdq_pkg::OP_ENQ;
    new_cmd.level = in_data.priority_req;
    new_cmd.tag   = in_data.item_tag;
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    case ({push, pop})
      2'b10:   count_nxt = count_r + 2'd1;
      2'b01:   count_nxt = count_r - 2'd1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= new_cmd;
    end
  end

  assign req.valid = (count_r != 2'd0);
  assign req.cmd   = fifo_r[rd_ptr_r];

endmodule

`default_nettype wire

// ===== hw/rtl/fdq_back.sv =====
// Back end: holds the four tag queues and carries out enqueue and drain commands.
`default_nettype none

module fdq_back #(
  parameter int QUEUE_DEPTH = fdq_pkg::DEF_QUEUE_DEPTH,
  parameter int TAG_BITS    = fdq_pkg::DEF_TAG_BITS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire fdq_pkg::fdq_req_t req,
  output logic                   cmd_pop,
  output logic                   out_valid,
  output fdq_pkg::fdq_out_t      out_data
);

  localparam int LEVELS    = fdq_pkg::LEVELS;
  localparam int LVL_W     = fdq_pkg::LVL_W;
  localparam int SLOT_W    = $clog2(QUEUE_DEPTH);
  localparam int OCC_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W    = SLOT_W + LVL_W;
  localparam int MEM_DEPTH = 2 ** ADDR_W;

  typedef enum logic {
    S_IDLE,
    S_DRAIN
  } state_t;

  // Position inside the two-to-one interleave of levels 2 and 3.
  typedef enum logic [1:0] {
    PH_FIRST,
    PH_SECOND,
    PH_LOW
  } phase_t;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;

  logic [SLOT_W-1:0] head_r [LEVELS];
  logic [OCC_W-1:0]  occ_r  [LEVELS];
  logic [SLOT_W-1:0] head_nxt [LEVELS];
  logic [OCC_W-1:0]  occ_nxt  [LEVELS];

  logic [TAG_BITS-1:0] tag_mem_r [MEM_DEPTH];
  logic [TAG_BITS-1:0] rd_data_r;

  logic                    out_valid_r, out_valid_nxt;
  logic [1:0]              status_r, status_nxt;
  logic [LVL_W-1:0]        level_r, level_nxt;
  logic                    last_r, last_nxt;
  logic                    from_mem_r, from_mem_nxt;
  logic [fdq_pkg::TAG_W-1:0] enq_tag_r, enq_tag_nxt;

  logic [LEVELS-1:0]   nonempty;
  logic [LVL_W-1:0]    sel;
  phase_t              sel_phase;
  logic                others_clear;
  logic                last_pop;

  logic [LVL_W-1:0]    e_lvl;
  logic                e_full;
  logic [SLOT_W:0]     tail_sum;
  logic [SLOT_W-1:0]   tail;

  logic [fdq_pkg::EXT_W-1:0] in_ext, back_ext, rd_ext;
  logic [TAG_BITS-1:0]       wr_tag;
  logic [fdq_pkg::TAG_W-1:0] enq_tag;

  logic                mem_we, mem_re;
  logic [ADDR_W-1:0]   wr_addr, rd_addr;

  // Tags are cut to TAG_BITS when stored and shown zero-extended to 32 bits.
  assign in_ext   = fdq_pkg::EXT_W'(req.cmd.tag);
  assign wr_tag   = in_ext[TAG_BITS-1:0];
  assign back_ext = fdq_pkg::EXT_W'(wr_tag);
  assign enq_tag  = back_ext[fdq_pkg::TAG_W-1:0];
  assign rd_ext   = fdq_pkg::EXT_W'(rd_data_r);

  always_comb begin
    for (int i = 0; i < LEVELS; i++) begin
      nonempty[i] = (occ_r[i] != '0);
    end
  end

  // Service order: level 0, level 1, then two of level 2 for each one of level 3.
  always_comb begin
    sel       = LVL_W'(3);
    sel_phase = phase_r;
    if (nonempty[0]) begin
      sel = LVL_W'(0);
    end else if (nonempty[1]) begin
      sel = LVL_W'(1);
    end else begin
      case (phase_r)
        PH_FIRST: begin
          if (nonempty[2]) begin
            sel       = LVL_W'(2);
            sel_phase = PH_SECOND;
          end
        end
        PH_SECOND: begin
          if (nonempty[2]) begin
            sel       = LVL_W'(2);
            sel_phase = PH_LOW;
          end else begin
            sel_phase = PH_FIRST;
          end
        end
        PH_LOW: begin
          if (nonempty[3]) begin
            sel_phase = PH_FIRST;
          end else begin
            sel       = LVL_W'(2);
            sel_phase = PH_SECOND;
          end
        end
        default: begin
          sel_phase = PH_FIRST;
        end
      endcase
    end
  end

  always_comb begin
    others_clear = 1'b1;
    for (int i = 0; i < LEVELS; i++) begin
      if ((LVL_W'(i) != sel) && nonempty[i]) begin
        others_clear = 1'b0;
      end
    end
  end

  assign last_pop = others_clear && (occ_r[sel] == OCC_W'(1));

  assign e_lvl    = req.cmd.level;
  assign e_full   = (occ_r[e_lvl] == OCC_W'(QUEUE_DEPTH));
  assign tail_sum = (SLOT_W + 1)'(head_r[e_lvl]) + (SLOT_W + 1)'(occ_r[e_lvl]);

  always_comb begin
    if (tail_sum >= (SLOT_W + 1)'(QUEUE_DEPTH)) begin
      tail = SLOT_W'(tail_sum - (SLOT_W + 1)'(QUEUE_DEPTH));
    end else begin
      tail = tail_sum[SLOT_W-1:0];
    end
  end

  assign wr_addr = {e_lvl, tail};
  assign rd_addr = {sel, head_r[sel]};
  assign cmd_pop = (state_r == S_IDLE) && req.valid;

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    head_nxt      = head_r;
    occ_nxt       = occ_r;
    out_valid_nxt = 1'b0;
    status_nxt    = status_r;
    level_nxt     = level_r;
    last_nxt      = last_r;
    from_mem_nxt  = from_mem_r;
    enq_tag_nxt   = enq_tag_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (req.valid) begin
          if (req.cmd.op == fdq_pkg::OP_ENQ) begin
            out_valid_nxt = 1'b1;
            level_nxt     = e_lvl;
            last_nxt      = 1'b1;
            from_mem_nxt  = 1'b0;
            enq_tag_nxt   = enq_tag;
            if (e_full) begin
              status_nxt = fdq_pkg::ST_DROPPED;
            end else begin
              status_nxt     = fdq_pkg::ST_ACCEPTED;
              mem_we         = 1'b1;
              occ_nxt[e_lvl] = occ_r[e_lvl] + OCC_W'(1);
            end
          end else if (|nonempty) begin
            state_nxt = S_DRAIN;
            phase_nxt = PH_FIRST;
          end
        end
      end
      S_DRAIN: begin
        mem_re        = 1'b1;
        out_valid_nxt = 1'b1;
        status_nxt    = fdq_pkg::ST_SERVED;
        level_nxt     = sel;
        last_nxt      = last_pop;
        from_mem_nxt  = 1'b1;
        phase_nxt     = sel_phase;
        occ_nxt[sel]  = occ_r[sel] - OCC_W'(1);
        if (head_r[sel] == SLOT_W'(QUEUE_DEPTH - 1)) begin
          head_nxt[sel] = '0;
        end else begin
          head_nxt[sel] = head_r[sel] + SLOT_W'(1);
        end
        if (last_pop) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_FIRST;
      out_valid_r <= 1'b0;
      for (int i = 0; i < LEVELS; i++) begin
        head_r[i] <= '0;
        occ_r[i]  <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
      occ_r       <= occ_nxt;
      status_r    <= status_nxt;
      level_r     <= level_nxt;
      last_r      <= last_nxt;
      from_mem_r  <= from_mem_nxt;
      enq_tag_r   <= enq_tag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tag_mem_r[wr_addr] <= wr_tag;
    end
    if (mem_re) begin
      rd_data_r <= tag_mem_r[rd_addr];
    end
  end

  assign out_valid             = out_valid_r;
  assign out_data.status       = status_r;
  assign out_data.served_tag   = from_mem_r ? rd_ext[fdq_pkg::TAG_W-1:0] : enq_tag_r;
  assign out_data.served_level = level_r;
  assign out_data.last_of_run  = last_r;

endmodule

`default_nettype wire

// ===== hw/rtl/four_level_priority_drain_queue.sv =====
// Top level of the four-level priority drain queue: front end, back end and checks.
//
// Usage:
//   Input beats are offered on in_data with start; a beat is taken at a rising edge
//   where start is high and busy is low. action 0 appends item_tag to the queue of
//   priority_req (QUEUE_DEPTH entries per level); action 1 drains all four queues.
//   Results appear on out_data for exactly one cycle while out_valid is high; the
//   receiver has no way to hold them off, so it must take every beat.
//   An enqueue gives one result (accepted or dropped, last_of_run set) from the
//   back-end output registers, and back-to-back enqueues sustain one per cycle.
//   A drain gives one result per stored tag, one per cycle, from its drain state,
//   with last_of_run on the final one; an empty drain gives none.
//   A drain occupies the back end until its last tag is read, as the tag memory has
//   a single read port; up to two further beats wait in the front queue meanwhile,
//   and busy rises when that queue is full.
//   Reset (rst_n low, synchronous) empties all queues and the front queue at once;
//   the tag memory itself is not cleared and needs no clearing pass.
`default_nettype none

module four_level_priority_drain_queue #(
  parameter int QUEUE_DEPTH = fdq_pkg::DEF_QUEUE_DEPTH,
  parameter int TAG_BITS    = fdq_pkg::DEF_TAG_BITS
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire fdq_pkg::fdq_in_t in_data,
  output logic                  out_valid,
  output fdq_pkg::fdq_out_t     out_data
);

`include "assert_macros.svh"

  fdq_pkg::fdq_req_t req;
  logic              cmd_pop;

  fdq_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_data (in_data),
    .cmd_pop (cmd_pop),
    .req     (req)
  );

  fdq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TAG_BITS    (TAG_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .cmd_pop   (cmd_pop),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // A full front queue always presents a command to the back end.
  `FDQ_ASSERT_IMPL(a_busy_has_cmd, busy, req.valid, "busy while no command is queued")

  // The back end only pops a command that is actually there.
  `FDQ_ASSERT_IMPL(a_pop_valid, cmd_pop, req.valid, "command popped from an empty queue")

  // Every enqueue produces its result beat on the next cycle.
  `FDQ_ASSERT_NEXT(a_enq_result, cmd_pop && (req.cmd.op == fdq_pkg::OP_ENQ), out_valid, "enqueue without a result beat")

  // Enqueue results are always the single, final beat of their item.
  `FDQ_ASSERT_IMPL(a_enq_last, out_valid && (out_data.status != fdq_pkg::ST_SERVED), out_data.last_of_run, "enqueue result not marked last")

endmodule

`default_nettype wire
